>>> hw/rtl/array_list_table_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Array list table engine: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define ARRAY_LIST_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/alte_pkg.sv
// ----------------------------------------------------------------------------
// Array list table engine package
// Word types, operation and status codes, controller states and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package alte_pkg;

    // Fixed field widths.
    localparam int FUNC_W  = 3;
    localparam int COUNT_W = 5;
    localparam int FIDX_W  = 4;
    localparam int STAT_W  = 3;
    localparam int DATA_W  = 32;

    // Default store depth, list-all result limit and capacity after reset.
    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_END   = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_REM_FRONT = 3'd3,
        FN_REM_END   = 3'd4,
        FN_REM_POS   = 3'd5,
        FN_SEARCH    = 3'd6,
        FN_LIST_ALL  = 3'd7
    } t_func;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DN,
        S_SCAN,
        S_LIST
    } t_state;

    // Input word.
    typedef struct packed {
        t_func                     func;
        logic [COUNT_W-1:0]        pos;
        logic signed [DATA_W-1:0]  value;
    } t_item;

    // Result word.
    typedef struct packed {
        t_status                   status;
        logic [FIDX_W-1:0]         found_index;
        logic signed [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/array_list_table_engine_top.sv
// ----------------------------------------------------------------------------
// Array list table engine
// Ordered list of signed 32-bit values kept in one synchronous memory, with
// insert, remove, search and list-all operations.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every word
// produces one result word, except a list-all on a non-empty list, which
// produces one word per entry (at most 16) with last set on the final one.
// Results appear on o_result for one cycle with o_strobe and cannot be held
// off. All work goes through a walk of the element memory, one
// entry per cycle, so with F entries in the list and P the position used:
// an error result leaves busy low, an insert shifts entries F - 1 down to P
// up one place and then writes the new value, a remove shifts entries P + 1
// to F - 1 down one place, a search examines entries in order up to a match
// and a list-all emits one word per entry. The last result word is on the
// outputs in the first cycle with busy low again (the cycle after the command
// when busy never rises), and a new command may be given in that cycle. The
// memory needs no clearing pass: only entries below the fill count are used.
`default_nettype none

`include "array_list_table_engine_top_assert.svh"

module array_list_table_engine_top #(
    parameter int DEPTH = alte_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  alte_pkg::t_item                   i_item,
    input  logic                              i_cfg_we,
    input  logic [alte_pkg::COUNT_W-1:0]      i_cfg_wdata,
    output logic                              o_strobe,
    output alte_pkg::t_result                 o_result
);
    import alte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] LIST_END = COUNT_W'(MAX_RESULTS - 1);

    // Control and payload registers.
    t_state                    r_state, n_state;
    logic [COUNT_W-1:0]        r_fill, n_fill;
    logic [COUNT_W-1:0]        r_cap;
    logic [COUNT_W-1:0]        r_ptr, n_ptr;
    logic [COUNT_W-1:0]        r_at, n_at;
    logic [COUNT_W-1:0]        r_end, n_end;
    logic signed [DATA_W-1:0]  r_value, n_value;
    logic                      r_strobe, n_strobe;
    t_result                   r_out, n_out;

    // Element memory and its port signals.
    logic signed [DATA_W-1:0]  r_mem [DEPTH];
    logic signed [DATA_W-1:0]  r_rdata;
    logic                      w_we;
    logic [COUNT_W-1:0]        w_waddr;
    logic signed [DATA_W-1:0]  w_wdata;
    logic [AW-1:0]             w_rd_addr;

    // Command decode.
    logic [COUNT_W-1:0]        w_at;
    logic [COUNT_W-1:0]        w_fill_m1;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_is_ins;
    logic                      w_is_rem;
    logic                      w_match;

    assign w_fill_m1 = r_fill - COUNT_W'(1);
    assign w_empty   = (r_fill == '0);
    assign w_full    = (r_fill >= r_cap) || (32'(r_fill) >= 32'(DEPTH));
    assign w_match   = (r_rdata == r_value);
    assign w_is_ins  = (i_item.func == FN_INS_FRONT) || (i_item.func == FN_INS_END) ||
                       (i_item.func == FN_INS_POS);
    assign w_is_rem  = (i_item.func == FN_REM_FRONT) || (i_item.func == FN_REM_END) ||
                       (i_item.func == FN_REM_POS);

    // Position that an insert or remove works on.
    always_comb begin
        case (i_item.func) inside
            FN_INS_FRONT, FN_REM_FRONT: w_at = '0;
            FN_INS_END:                 w_at = r_fill;
            FN_REM_END:                 w_at = w_fill_m1;
            default:                    w_at = i_item.pos;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_is_ins) begin
                        if (!w_full && (w_at <= r_fill)) begin
                            n_state = (w_at == r_fill) ? S_PUT : S_UP;
                        end
                    end else if (w_is_rem) begin
                        if (!w_empty && (w_at < r_fill) && (w_at != w_fill_m1)) begin
                            n_state = S_DN;
                        end
                    end else if (i_item.func == FN_SEARCH) begin
                        if (!w_empty) begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (!w_empty) begin
                            n_state = S_LIST;
                        end
                    end
                end
            end
            S_UP:   n_state = (r_ptr == r_at) ? S_PUT : S_UP;
            S_PUT:  n_state = S_IDLE;
            S_DN:   n_state = (r_ptr == r_end) ? S_IDLE : S_DN;
            S_SCAN: n_state = (w_match || (r_ptr == r_end)) ? S_IDLE : S_SCAN;
            S_LIST: n_state = (r_ptr == r_end) ? S_IDLE : S_LIST;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory port and result word.
    always_comb begin
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        n_at     = r_at;
        n_end    = r_end;
        n_value  = r_value;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        n_strobe = 1'b0;
        n_out             = '0;
        n_out.status      = ST_OK;
        n_out.count       = r_fill;
        n_out.last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_at    = w_at;
                    n_value = i_item.value;
                    if (w_is_ins) begin
                        if (w_full) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_FULL;
                        end else if (w_at > r_fill) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_BADPOS;
                        end else begin
                            n_ptr = w_fill_m1;
                        end
                    end else if (w_is_rem) begin
                        if (w_empty) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_EMPTY;
                        end else if (w_at >= r_fill) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_BADPOS;
                        end else if (w_at == w_fill_m1) begin
                            // Removing the tail needs no shift.
                            n_fill       = w_fill_m1;
                            n_strobe     = 1'b1;
                            n_out.count  = w_fill_m1;
                        end else begin
                            n_ptr = w_at + COUNT_W'(1);
                            n_end = w_fill_m1;
                        end
                    end else if (i_item.func == FN_SEARCH) begin
                        if (w_empty) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_NOTFOUND;
                        end else begin
                            n_ptr = '0;
                            n_end = w_fill_m1;
                        end
                    end else begin
                        if (w_empty) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_ptr = '0;
                            n_end = (r_fill > LIST_END) ? LIST_END : w_fill_m1;
                        end
                    end
                end
            end
            S_UP: begin
                // Move the entry read last cycle one place up.
                w_we    = 1'b1;
                w_waddr = r_ptr + COUNT_W'(1);
                w_wdata = r_rdata;
                if (r_ptr != r_at) begin
                    n_ptr = r_ptr - COUNT_W'(1);
                end
            end
            S_PUT: begin
                w_we        = 1'b1;
                w_waddr     = r_at;
                w_wdata     = r_value;
                n_fill      = r_fill + COUNT_W'(1);
                n_strobe    = 1'b1;
                n_out.count = r_fill + COUNT_W'(1);
            end
            S_DN: begin
                // Move the entry read last cycle one place down.
                w_we    = 1'b1;
                w_waddr = r_ptr - COUNT_W'(1);
                w_wdata = r_rdata;
                if (r_ptr == r_end) begin
                    n_fill      = w_fill_m1;
                    n_strobe    = 1'b1;
                    n_out.count = w_fill_m1;
                end else begin
                    n_ptr = r_ptr + COUNT_W'(1);
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_strobe          = 1'b1;
                    n_out.found_index = FIDX_W'(r_ptr);
                end else if (r_ptr == r_end) begin
                    n_strobe     = 1'b1;
                    n_out.status = ST_NOTFOUND;
                end else begin
                    n_ptr = r_ptr + COUNT_W'(1);
                end
            end
            S_LIST: begin
                n_strobe       = 1'b1;
                n_out.data_out = r_rdata;
                n_out.last     = (r_ptr == r_end);
                if (r_ptr != r_end) begin
                    n_ptr = r_ptr + COUNT_W'(1);
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    // The read address follows n_ptr, so r_rdata holds the entry at r_ptr.
    // Writes and reads in one cycle target different entries, except the
    // final write of an insert after a shift, which reads unused data. Busy
    // keeps a new command off until the last write of a shift has landed.
    assign w_rd_addr = AW'(n_ptr);

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(w_waddr)] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cap    <= CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_at    <= n_at;
        r_end   <= n_end;
        r_value <= n_value;
        r_out   <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Checks.
    `ALTE_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, (32'(r_fill) <= 32'(DEPTH)), "fill count exceeds store depth")
    `ALTE_ASSERT_IMPLY(a_err_last, i_clk, i_rst_n, (o_strobe && (o_result.status != ST_OK)), (o_result.last && (o_result.data_out == '0)), "error result not a single final word")
    `ALTE_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n, 1'b1, ((r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + COUNT_W'(1)) || (r_fill == $past(r_fill) - COUNT_W'(1))), "fill count moved by more than one")
    `ALTE_ASSERT_NEXT(a_search_walk, i_clk, i_rst_n, (start && !busy && (i_item.func == FN_SEARCH) && (r_fill != '0)), (r_state == S_SCAN), "search on non-empty list did not start a scan")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Array list table engine testbench
// Drives command words through the start/busy handshake and keeps its own
// model of the list. Each result word is checked field by field against the
// oldest predicted word. The capacity register is changed between phases.
// A directed opening covers the corner cases and random traffic follows,
// made of phases that grow and shrink the list.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alte_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_WORDS    = 53;

    // One entry of the stimulus: a command word or a capacity write.
    typedef struct {
        bit                  is_cfg;
        t_item               item;
        logic [COUNT_W-1:0]  cap;
    } t_cmd;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_item               item_word = '0;
    logic                cfg_we = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    logic                strobe;
    t_result             result_word;

    t_cmd                cmd_q[$];
    t_result             expected_words[$];
    logic                took_word = 1'b0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;

    // Model of the list, updated as command words are accepted.
    logic [DATA_W-1:0]   list_mem[DEPTH_DEF];
    int                  list_len = 0;
    int                  cap_model = int'(CAP_RESET);

    // Sender pacing.
    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  settle = 0;

    array_list_table_engine_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_strobe    (strobe),
        .o_result    (result_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------

    function automatic void push_word(t_status st, int idx, logic [DATA_W-1:0] data,
                                      logic last);
        t_result w;
        w.status      = st;
        w.found_index = FIDX_W'(idx);
        w.data_out    = data;
        w.count       = COUNT_W'(list_len);
        w.last        = last;
        expected_words.push_back(w);
    endfunction

    function automatic t_status list_insert(int at, logic [DATA_W-1:0] v);
        int room;
        room = (cap_model < DEPTH_DEF) ? cap_model : DEPTH_DEF;
        if (list_len >= room)
            return ST_FULL;
        if (at > list_len)
            return ST_BADPOS;
        for (int i = list_len; i > at; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[at] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic t_status list_remove(int at);
        if (list_len == 0)
            return ST_EMPTY;
        if (at >= list_len)
            return ST_BADPOS;
        for (int i = at; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
        return ST_OK;
    endfunction

    // Applies one command word to the model and queues the words it yields.
    function automatic void apply_list_op(t_item w);
        t_status st;
        int      n;
        st = ST_OK;
        case (w.func)
            FN_INS_FRONT: st = list_insert(0, w.value);
            FN_INS_END:   st = list_insert(list_len, w.value);
            FN_INS_POS:   st = list_insert(int'(w.pos), w.value);
            FN_REM_FRONT: st = list_remove(0);
            FN_REM_END:   st = (list_len == 0) ? ST_EMPTY : list_remove(list_len - 1);
            FN_REM_POS:   st = list_remove(int'(w.pos));
            FN_SEARCH: begin
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == w.value) begin
                        push_word(ST_OK, i, '0, 1'b1);
                        return;
                    end
                end
                st = ST_NOTFOUND;
            end
            default: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    n = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
                    for (int i = 0; i < n; i++)
                        push_word(ST_OK, 0, list_mem[i], i + 1 == n);
                    return;
                end
            end
        endcase
        push_word(st, 0, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_op(t_func f, int p, logic [DATA_W-1:0] v);
        t_cmd c;
        c.is_cfg     = 1'b0;
        c.item.func  = f;
        c.item.pos   = COUNT_W'(p);
        c.item.value = v;
        c.cap        = '0;
        cmd_q.push_back(c);
    endtask

    task automatic queue_capacity(int cap);
        t_cmd c;
        c.is_cfg = 1'b1;
        c.item   = '0;
        c.cap    = COUNT_W'(cap);
        cmd_q.push_back(c);
    endtask

    // Mix of small values (so duplicates occur), extremes and full-range values.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Builds one random phase: grows the list in its first half, shrinks it
    // in its second. A rough length estimate keeps most positions in range.
    task automatic queue_phase(int cap, int words, ref logic [DATA_W-1:0] pool[$]);
        int                 est_len;
        int                 r;
        int                 p;
        bit                 grow;
        t_func              f;
        logic [DATA_W-1:0]  v;
        est_len = 0;
        queue_capacity(cap);
        for (int k = 0; k < words; k++) begin
            grow = (k < words / 2);
            r    = $urandom_range(0, 99);
            v    = pick_value();
            if ($urandom_range(0, 19) == 0) begin
                // Noise: any operation, any position.
                queue_op(t_func'($urandom_range(0, 7)), $urandom_range(0, 16), v);
            end else if (r < (grow ? 55 : 20)) begin
                f = t_func'($urandom_range(0, 2));
                p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16)
                                                : $urandom_range(0, est_len);
                queue_op(f, p, v);
                pool.push_back(v);
                if (pool.size() > 32)
                    void'(pool.pop_front());
                if (est_len < cap && est_len < DEPTH_DEF && (f != FN_INS_POS || p <= est_len))
                    est_len++;
            end else if (r < 75) begin
                f = t_func'($urandom_range(3, 5));
                p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16)
                                                : $urandom_range(0, (est_len > 0) ? est_len - 1 : 0);
                queue_op(f, p, v);
                if (est_len > 0 && (f != FN_REM_POS || p < est_len))
                    est_len--;
            end else if (r < 90) begin
                if (pool.size() > 0 && $urandom_range(0, 9) < 7)
                    v = pool[$urandom_range(0, pool.size() - 1)];
                queue_op(FN_SEARCH, $urandom_range(0, 16), v);
            end else begin
                queue_op(FN_LIST_ALL, $urandom_range(0, 16), v);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: command words and capacity writes change at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        logic  nxt_start;
        logic  nxt_we;
        t_cmd  head;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (rst_n) begin
            // The word on the port was taken at the last rising edge.
            if (start && took_word) begin
                void'(cmd_q.pop_front());
                nxt_start = 1'b0;
            end
            if (!nxt_start && gap_left > 0)
                gap_left--;
            if (!nxt_start && gap_left == 0 && cmd_q.size() > 0) begin
                head = cmd_q[0];
                if (head.is_cfg) begin
                    // Capacity changes only once the block has gone quiet.
                    if (settle >= SETTLE_CYCLES) begin
                        nxt_we = 1'b1;
                        cfg_wdata <= head.cap;
                        void'(cmd_q.pop_front());
                    end
                end else begin
                    nxt_start = 1'b1;
                    item_word <= head.item;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            if (expected_words.size() == 0 && !busy && !nxt_start && !nxt_we)
                settle++;
            else
                settle = 0;
        end
        start  <= nxt_start;
        cfg_we <= nxt_we;
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result words and feeds accepted words to the model.
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        t_result want;
        took_word <= rst_n && start && !busy;
        if (rst_n) begin
            if (strobe) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: 0x%0h", result_word);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(result_word.status));
                    check_field("found_index", DATA_W'(want.found_index),
                                DATA_W'(result_word.found_index));
                    check_field("data_out", want.data_out, result_word.data_out);
                    check_field("count", DATA_W'(want.count), DATA_W'(result_word.count));
                    check_field("last", DATA_W'(want.last), DATA_W'(result_word.last));
                end
            end
            if (cfg_we)
                cap_model = int'(cfg_wdata);
            if (start && !busy)
                apply_list_op(item_word);
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0] pool[$];
        int                caps[8];

        // Empty-list errors.
        queue_op(FN_LIST_ALL, 0, '0);
        queue_op(FN_SEARCH, 0, '0);
        queue_op(FN_REM_FRONT, 0, '0);
        queue_op(FN_REM_END, 0, '0);
        queue_op(FN_REM_POS, 0, '0);
        // Insert positions past the end.
        queue_op(FN_INS_POS, 1, 32'd5);
        queue_op(FN_INS_POS, 16, 32'd5);
        // Build a short list with extreme and duplicate values.
        queue_op(FN_INS_FRONT, 0, 32'h7fff_ffff);
        queue_op(FN_INS_END, 0, 32'h8000_0000);
        queue_op(FN_INS_POS, 1, 32'hffff_ffff);
        queue_op(FN_INS_POS, 3, 32'h0000_0000);
        queue_op(FN_INS_POS, 2, 32'hffff_ffff);
        // First match wins; a miss reports not found.
        queue_op(FN_SEARCH, 0, 32'hffff_ffff);
        queue_op(FN_SEARCH, 0, 32'd12345);
        queue_op(FN_REM_POS, 5, '0);
        queue_op(FN_LIST_ALL, 0, '0);
        queue_op(FN_REM_POS, 1, '0);
        queue_op(FN_REM_FRONT, 0, '0);
        queue_op(FN_REM_END, 0, '0);
        // Capacity lowered below the fill level: inserts stay full until removals bring the fill below it.
        queue_capacity(1);
        queue_op(FN_INS_END, 0, 32'd3);
        queue_op(FN_REM_POS, 0, '0);
        queue_op(FN_INS_FRONT, 0, 32'd4);
        queue_op(FN_REM_END, 0, '0);
        queue_op(FN_INS_POS, 0, 32'd6);
        // Zero capacity keeps the entry but refuses every insert.
        queue_capacity(0);
        queue_op(FN_INS_FRONT, 0, 32'd8);
        queue_op(FN_LIST_ALL, 0, '0);

        // Random phases over a spread of capacities, extremes included.
        caps = '{16, 5, 16, 0, 11, 1, $urandom_range(2, 15), 16};
        foreach (caps[i])
            queue_phase(caps[i], (caps[i] == 0) ? 15 : PHASE_WORDS, pool);

        // Reset held from the start, released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every result to arrive.
        while (cmd_q.size() > 0 || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/alte_pkg.sv
hw/rtl/array_list_table_engine_top.sv
sim/testbench.sv
